### hw/rtl/bdai_pkg.sv
// ----------------------------------------------------------------------------
// Bracket depth auto indenter package
// Shared codes, character constants, payload structs and a column helper.
// ----------------------------------------------------------------------------
package bdai_pkg;

  // Default configuration of the indenter.
  localparam int unsigned TabWidthDef = 8;
  localparam int unsigned MaxDepthDef = 15;

  // Field widths.
  localparam int unsigned CmdW   = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ColW   = 8;
  localparam int unsigned TabsW  = 5;
  localparam int unsigned CountW = 32;
  // Wide enough for TAB_WIDTH * (depth + 2) and for a column plus one tab stop.
  localparam int unsigned WideW  = 10;

  localparam logic [ColW-1:0]  COL_MAX = 8'd255;
  localparam logic [TabsW-1:0] TAB_CAP = 5'd31;

  // Command codes.
  localparam logic [CmdW-1:0] CMD_CHAR        = 2'd0;
  localparam logic [CmdW-1:0] CMD_INDENT_MORE = 2'd1;
  localparam logic [CmdW-1:0] CMD_INDENT_LESS = 2'd2;

  // Continuation codes.
  localparam logic [1:0] CONT_NONE   = 2'd0;
  localparam logic [1:0] CONT_BSLASH = 2'd1;
  localparam logic [1:0] CONT_LINE   = 2'd2;

  // Characters with a special meaning.
  localparam logic [ByteW-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [ByteW-1:0] CH_SPACE   = 8'h20;
  localparam logic [ByteW-1:0] CH_TAB     = 8'h09;
  localparam logic [ByteW-1:0] CH_ALIGN   = 8'h01;
  localparam logic [ByteW-1:0] CH_HASH    = 8'h23;
  localparam logic [ByteW-1:0] CH_BSLASH  = 8'h5C;
  localparam logic [ByteW-1:0] CH_LPAREN  = 8'h28;
  localparam logic [ByteW-1:0] CH_RPAREN  = 8'h29;
  localparam logic [ByteW-1:0] CH_LBRACK  = 8'h5B;
  localparam logic [ByteW-1:0] CH_RBRACK  = 8'h5D;
  localparam logic [ByteW-1:0] CH_LBRACE  = 8'h7B;
  localparam logic [ByteW-1:0] CH_RBRACE  = 8'h7D;

  // One input beat.
  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [ByteW-1:0] in_byte;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [TabsW-1:0]  tab_count;
    logic [ColW-1:0]   space_count;
    logic [ByteW-1:0]  out_byte;
    logic              byte_valid;
    logic [CountW-1:0] byte_position;
  } result_t;

  // Clamp a wide column value to the largest column.
  function automatic logic [ColW-1:0] sat_col(input logic [WideW-1:0] v);
    logic [ColW-1:0] r;
    r = (v > WideW'(COL_MAX)) ? COL_MAX : v[ColW-1:0];
    return r;
  endfunction

endpackage

### hw/rtl/bdai_in_stage.sv
// ----------------------------------------------------------------------------
// Bracket depth auto indenter input stage
// Registers one input beat and hands it to the core when the result side
// can take it.
// ----------------------------------------------------------------------------
module bdai_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bdai_pkg::item_t in_item_i,
  output logic            item_valid_o,
  input  logic            item_ready_i,
  output bdai_pkg::item_t item_o
);
  import bdai_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // The register frees up whenever its beat moves on in the same cycle.
  assign in_ready_o = !valid_q || item_ready_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### hw/rtl/bdai_core.sv
// ----------------------------------------------------------------------------
// Bracket depth auto indenter core
// Holds the depth, column, continuation and count state and works out the
// whitespace runs for one beat in a single pass.
// ----------------------------------------------------------------------------
module bdai_core #(
  parameter int unsigned TAB_WIDTH = bdai_pkg::TabWidthDef,
  parameter int unsigned MAX_DEPTH = bdai_pkg::MaxDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  bdai_pkg::item_t   item_i,
  output bdai_pkg::result_t result_o
);
  import bdai_pkg::*;

  localparam int unsigned DepthW = $clog2(MAX_DEPTH + 1);
  localparam logic [DepthW-1:0] DEPTH_TOP = DepthW'(MAX_DEPTH);
  // Reciprocal of the tab width; exact floor for any 8-bit column.
  localparam int unsigned RecipW = 17;
  localparam logic [RecipW-1:0] RECIP = RecipW'((65536 + TAB_WIDTH - 1) / TAB_WIDTH);
  localparam int unsigned ProdW = ColW + RecipW;
  // Most tabs that fit below the column limit, also capped by the tab field.
  localparam int unsigned TabsLimInt = (255 / TAB_WIDTH > 31) ? 31 : 255 / TAB_WIDTH;
  localparam logic [TabsW-1:0] TABS_LIM = TabsW'(TabsLimInt);
  localparam logic [WideW-1:0] TW_WIDE = WideW'(TAB_WIDTH);

  logic [DepthW-1:0] depth_q, depth_d;
  logic [ColW-1:0]   want_q, want_d;
  logic [ColW-1:0]   done_q, done_d;
  logic [1:0]        cont_q, cont_d;
  logic [CountW-1:0] count_q, count_d;

  logic [DepthW-1:0] depth_inc, depth_dec, depth_a;
  logic [ProdW-1:0]  tab_prod;
  logic [ColW-1:0]   tab_quot;
  logic [ColW-1:0]   tab_stop;
  logic [ColW-1:0]   want_inc;
  logic [ColW-1:0]   align_col;
  logic [ColW-1:0]   indent_col;
  logic [ColW-1:0]   want_a;
  logic [ColW-1:0]   done_a;
  logic [TabsW-1:0]  tabs_a;
  logic [ColW-1:0]   spaces_a;
  logic [ColW-1:0]   want_after;
  logic              line_start;
  logic              is_open, is_close, indent_en;
  logic [ByteW-1:0]  c;

  assign c          = item_i.in_byte;
  assign line_start = (done_q == '0);

  // Saturating depth steps.
  assign depth_inc = (depth_q < DEPTH_TOP) ? depth_q + 1'b1 : depth_q;
  assign depth_dec = (depth_q != '0) ? depth_q - 1'b1 : depth_q;

  // Next tab stop inside a line: (want / TAB_WIDTH + 1) * TAB_WIDTH.
  assign tab_prod = ProdW'(want_q) * ProdW'(RECIP);
  assign tab_quot = tab_prod[ColW+15:16];
  assign tab_stop = sat_col((WideW'(tab_quot) + 1'b1) * TW_WIDE);
  assign want_inc = sat_col(WideW'(want_q) + 1'b1);

  // Alignment column for depth plus two.
  assign align_col = sat_col(TW_WIDE * (WideW'(depth_q) + WideW'(2)));

  // Bracket classes of a printing byte.
  assign is_open  = (c == CH_LPAREN) || (c == CH_LBRACK) || (c == CH_LBRACE);
  assign is_close = (c == CH_RPAREN) || (c == CH_RBRACK) || (c == CH_RBRACE);
  assign depth_a  = is_close ? depth_dec : depth_q;

  // Depth indent at line start. The wanted column is zero there, so the tab
  // run is the depth itself until the column limit or the tab cap is hit.
  assign indent_en  = line_start && (c != CH_HASH) && (cont_q != CONT_LINE);
  assign indent_col = sat_col(TW_WIDE * WideW'(depth_a));
  assign want_a     = indent_en ? indent_col : want_q;
  assign tabs_a     = !indent_en ? '0
                    : ((TabsW'(depth_a) > TABS_LIM) ? TABS_LIM : TabsW'(depth_a));
  assign done_a     = line_start ? ColW'(WideW'(tabs_a) * TW_WIDE) : done_q;
  assign spaces_a   = (done_a < want_a) ? want_a - done_a : '0;
  assign want_after = sat_col(WideW'(want_a) + 1'b1);

  // Next state and result for the beat in flight.
  always_comb begin
    depth_d  = depth_q;
    want_d   = want_q;
    done_d   = done_q;
    cont_d   = cont_q;
    count_d  = count_q;
    result_o = '0;
    case (item_i.cmd)
      CMD_INDENT_MORE: begin
        depth_d = depth_inc;
      end
      CMD_INDENT_LESS: begin
        depth_d = depth_dec;
      end
      CMD_CHAR: begin
        count_d = count_q + 1'b1;
        if (c == CH_NEWLINE) begin
          want_d              = '0;
          done_d              = '0;
          cont_d              = (cont_q == CONT_BSLASH) ? CONT_LINE : CONT_NONE;
          result_o.out_byte   = c;
          result_o.byte_valid = 1'b1;
        end else if (c == CH_SPACE) begin
          if (!line_start) begin
            want_d = want_inc;
          end
        end else if (c == CH_TAB) begin
          if (!line_start) begin
            want_d = tab_stop;
          end
        end else if (c == CH_ALIGN) begin
          if (!line_start) begin
            want_d = (want_q >= align_col) ? want_inc : align_col;
          end
        end else begin
          depth_d              = is_open
                               ? ((depth_a < DEPTH_TOP) ? depth_a + 1'b1 : depth_a)
                               : depth_a;
          want_d               = want_after;
          done_d               = want_after;
          cont_d               = (c == CH_BSLASH) ? CONT_BSLASH : CONT_NONE;
          result_o.tab_count   = tabs_a;
          result_o.space_count = spaces_a;
          result_o.out_byte    = c;
          result_o.byte_valid  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    result_o.byte_position = count_d;
  end

  // State advances only when a beat moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      want_q  <= '0;
      done_q  <= '0;
      cont_q  <= CONT_NONE;
      count_q <= '0;
    end else if (fire_i) begin
      depth_q <= depth_d;
      want_q  <= want_d;
      done_q  <= done_d;
      cont_q  <= cont_d;
      count_q <= count_d;
    end
  end

endmodule

### hw/rtl/bdai_out_stage.sv
// ----------------------------------------------------------------------------
// Bracket depth auto indenter output stage
// Registers one result beat and holds it until the consumer takes it.
// ----------------------------------------------------------------------------
module bdai_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  output logic              res_ready_o,
  input  bdai_pkg::result_t res_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bdai_pkg::result_t res_o
);
  import bdai_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // Taking a new beat is allowed while the held one leaves this cycle.
  assign res_ready_o = !valid_q || out_ready_i;
  assign valid_d     = res_ready_o ? res_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### hw/rtl/bracket_depth_auto_indenter_unit.sv
// ----------------------------------------------------------------------------
// Bracket depth auto indenter unit
// A beat accepted into the input register passes through the single-pass core into
// the result register, which drives the outputs until the consumer takes it.
// Throughput: one beat per cycle while the consumer keeps taking results, set by
// the single-pass core between the input register and the result register.
// Reset clears the depth, both columns, the continuation state and the count.
// ----------------------------------------------------------------------------
module bracket_depth_auto_indenter_unit #(
  parameter int unsigned TAB_WIDTH = bdai_pkg::TabWidthDef,
  parameter int unsigned MAX_DEPTH = bdai_pkg::MaxDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bdai_pkg::CmdW-1:0]     cmd_i,
  input  logic [bdai_pkg::ByteW-1:0]    in_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bdai_pkg::TabsW-1:0]    tab_count_o,
  output logic [bdai_pkg::ColW-1:0]     space_count_o,
  output logic [bdai_pkg::ByteW-1:0]    out_byte_o,
  output logic                          byte_valid_o,
  output logic [bdai_pkg::CountW-1:0]   byte_position_o
);
  import bdai_pkg::*;

  item_t   in_item;
  item_t   core_item;
  logic    core_valid;
  logic    core_ready;
  result_t core_res;
  result_t out_res;

  assign in_item.cmd     = cmd_i;
  assign in_item.in_byte = in_byte_i;

  // Input register.
  bdai_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item),
    .item_valid_o (core_valid),
    .item_ready_i (core_ready),
    .item_o       (core_item)
  );

  // Indent state and single-pass result logic.
  bdai_core #(
    .TAB_WIDTH (TAB_WIDTH),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (core_valid && core_ready),
    .item_i   (core_item),
    .result_o (core_res)
  );

  // Result register.
  bdai_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (core_valid),
    .res_ready_o (core_ready),
    .res_i       (core_res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign tab_count_o     = out_res.tab_count;
  assign space_count_o   = out_res.space_count;
  assign out_byte_o      = out_res.out_byte;
  assign byte_valid_o    = out_res.byte_valid;
  assign byte_position_o = out_res.byte_position;

endmodule
